@@ sv/acqfr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acquisition frame receiver package
// Shared constants, result record type and sample scaling function.
// ----------------------------------------------------------------------------
package acqfr_pkg;

   localparam int MaxDatagramBytesDefault = 16384;

   localparam int WordW    = 64;
   localparam int BytesW   = 15;
   localparam int PosW     = 12;
   localparam int SampleW  = 16;
   localparam int SpcW     = 12;
   localparam int DecW     = 8;
   localparam int ReqDataW = 80;
   localparam int RspDataW = 312;

   localparam logic [31:0]     FrameMagic  = 32'h5250_4143;
   localparam logic [35:0]     HeaderBytes = 36'd32;
   localparam logic [PosW-1:0] PosMax      = 12'hFFF;
   localparam logic [PosW-1:0] PosMagic    = 12'd0;
   localparam logic [PosW-1:0] PosSeq      = 12'd1;
   localparam logic [PosW-1:0] PosTime     = 12'd2;
   localparam logic [PosW-1:0] PosCount    = 12'd3;
   localparam logic [PosW-1:0] PosPayload  = 12'd4;

   localparam logic KindHeader = 1'b0;
   localparam logic KindPair   = 1'b1;

   typedef struct packed {
      logic                      kind;
      logic [WordW-1:0]          frame_seq;
      logic [WordW-1:0]          frame_time;
      logic [SpcW-1:0]           samples_per_channel;
      logic [DecW-1:0]           decimation_log;
      logic [WordW-1:0]          fabric_drop_total;
      logic [WordW-1:0]          network_drop_total;
      logic signed [SampleW-1:0] sample_first;
      logic signed [SampleW-1:0] sample_second;
      logic                      last_pair;
   } rsp_fields_type;

   function automatic logic [SampleW-1:0] to_q15(input logic [SampleW-1:0] raw,
                                                 input logic bypass);
      logic [SampleW-1:0] res;
      res = raw;
      if (bypass) begin
         if (raw[15:13] == 3'b000 || raw[15:13] == 3'b111) begin
            res = {raw[13:0], 2'b00};
         end else if (raw[15]) begin
            res = 16'h8000;
         end else begin
            res = 16'h7FFF;
         end
      end
      return res;
   endfunction

endpackage

@@ sv/acq_frame_receiver_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Acquisition frame receiver
// Parses datagram headers, splits sequence drops and emits channel samples.
// ----------------------------------------------------------------------------
// One datagram word enters per cycle and passes through an input register and
// a result register, and the block sustains one item per cycle whenever the
// result side is ready. The fourth word of an accepted frame yields a header
// summary (kind 0) with updated drop totals; each payload word then yields one
// pair of samples (kind 1) of the channel chosen by csr_data. Words that fail
// validation yield nothing.
// ----------------------------------------------------------------------------
module acq_frame_receiver_top #(
   parameter int MAX_DATAGRAM_BYTES = acqfr_pkg::MaxDatagramBytesDefault
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   // data_word [63:0], datagram_bytes [78:64], zero pad [79]
   input  logic [acqfr_pkg::ReqDataW-1:0]  req_tdata,
   input  logic                            req_tlast,
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   // frame_seq [63:0], frame_time [127:64], samples_per_channel [139:128],
   // decimation_log [147:140], fabric_drop_total [211:148],
   // network_drop_total [275:212], sample_first [291:276],
   // sample_second [307:292], zero pad [311:308]
   output logic [acqfr_pkg::RspDataW-1:0]  rsp_tdata,
   // kind [0]
   output logic                            rsp_tuser,
   output logic                            rsp_tlast,
   input  logic                            csr_valid,
   output logic                            csr_ready,
   input  logic [0:0]                      csr_data
);
   import acqfr_pkg::*;

   localparam logic [31:0] MaxBytes = 32'(MAX_DATAGRAM_BYTES);
   localparam logic [31:0] MaxWords = 32'(MAX_DATAGRAM_BYTES / 8);

   logic                 chan_ff;

   logic                 in_valid_ff;
   logic [WordW-1:0]     in_word_ff;
   logic [BytesW-1:0]    in_bytes_ff;
   logic                 in_last_ff;

   logic [PosW-1:0]      pos_ff, pos_in;
   logic                 acc_ff, acc_in;
   logic [DecW-1:0]      dec_ff, dec_in;
   logic [31:0]          pw_ff, pw_in;
   logic [WordW-1:0]     seq_ff, seq_in;
   logic [WordW-1:0]     time_ff, time_in;
   logic [WordW-1:0]     prev_seq_ff, prev_seq_in;
   logic [31:0]          prev_dc_ff, prev_dc_in;
   logic                 seen_ff, seen_in;
   logic [WordW-1:0]     fab_tot_ff, fab_tot_in;
   logic [WordW-1:0]     net_tot_ff, net_tot_in;
   logic                 gt_ff, gt_in;
   logic                 eq_ff, eq_in;
   logic [WordW-1:0]     gap_ff, gap_in;

   logic                 rsp_valid_ff;
   rsp_fields_type       rsp_ff, rsp_in;

   logic                 out_free;
   logic                 proc;
   logic                 emit;

   logic [31:0]          dc;
   logic [31:0]          fab_raw;
   logic [WordW-1:0]     fab;
   logic [BytesW-1:0]    avail;
   logic [35:0]          need;
   logic [PosW-1:0]      k;
   logic                 bypass;

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign proc       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;
   assign csr_ready  = 1'b1;

   assign dc      = in_word_ff[31:0];
   assign fab_raw = (dc > prev_dc_ff) ? dc - prev_dc_ff : 32'd0;
   assign fab     = (gap_ff > {32'd0, fab_raw}) ? {32'd0, fab_raw} : gap_ff;
   assign avail   = ({17'd0, in_bytes_ff} < MaxBytes) ? in_bytes_ff : BytesW'(MaxBytes);
   assign need    = {1'b0, in_word_ff[63:32], 3'b000} + HeaderBytes;
   assign k       = pos_ff - PosPayload;
   assign bypass  = (dec_ff == '0);

   always_comb begin
      pos_in      = pos_ff;
      acc_in      = acc_ff;
      dec_in      = dec_ff;
      pw_in       = pw_ff;
      seq_in      = seq_ff;
      time_in     = time_ff;
      prev_seq_in = prev_seq_ff;
      prev_dc_in  = prev_dc_ff;
      seen_in     = seen_ff;
      fab_tot_in  = fab_tot_ff;
      net_tot_in  = net_tot_ff;
      gt_in       = gt_ff;
      eq_in       = eq_ff;
      gap_in      = gap_ff;
      emit        = 1'b0;
      rsp_in      = '0;
      if (proc) begin
         if (pos_ff == PosMagic) begin
            acc_in = (in_word_ff[31:0] == FrameMagic);
            dec_in = in_word_ff[55:48];
         end else if (pos_ff == PosSeq) begin
            seq_in = in_word_ff;
         end else if (pos_ff == PosTime) begin
            time_in = in_word_ff;
            gt_in   = $signed(seq_ff) > $signed(prev_seq_ff);
            eq_in   = (seq_ff == prev_seq_ff);
            gap_in  = seq_ff - prev_seq_ff - 64'd1;
         end else if (pos_ff == PosCount) begin
            pw_in = in_word_ff[63:32];
            if (acc_ff && in_word_ff[63:32] != '0 && {21'd0, avail} >= need) begin
               if (!seen_ff) begin
                  seen_in     = 1'b1;
                  prev_seq_in = seq_ff;
                  prev_dc_in  = dc;
               end else if (gt_ff) begin
                  fab_tot_in  = fab_tot_ff + fab;
                  net_tot_in  = net_tot_ff + (gap_ff - fab);
                  prev_seq_in = seq_ff;
                  prev_dc_in  = dc;
               end else if (!eq_ff) begin
                  prev_seq_in = seq_ff;
                  prev_dc_in  = dc;
               end
               emit                       = 1'b1;
               rsp_in.kind                = KindHeader;
               rsp_in.frame_seq           = seq_ff;
               rsp_in.frame_time          = time_ff;
               rsp_in.samples_per_channel = {in_word_ff[42:32], 1'b0};
               rsp_in.decimation_log      = dec_ff;
               rsp_in.fabric_drop_total   = fab_tot_in;
               rsp_in.network_drop_total  = net_tot_in;
            end else begin
               acc_in = 1'b0;
            end
         end else if (acc_ff) begin
            if ({20'd0, k} < pw_ff && {20'd0, pos_ff} < MaxWords) begin
               emit               = 1'b1;
               rsp_in.kind        = KindPair;
               rsp_in.sample_first  = to_q15(chan_ff ? in_word_ff[31:16] : in_word_ff[15:0],
                                             bypass);
               rsp_in.sample_second = to_q15(chan_ff ? in_word_ff[63:48] : in_word_ff[47:32],
                                             bypass);
               rsp_in.last_pair   = ({20'd0, k} + 32'd1 == pw_ff);
            end
         end
         if (in_last_ff) begin
            pos_in = '0;
            acc_in = 1'b0;
         end else if (pos_ff != PosMax) begin
            pos_in = pos_ff + 12'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         chan_ff      <= 1'b0;
         in_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
         pos_ff       <= '0;
         acc_ff       <= 1'b0;
         dec_ff       <= '0;
         pw_ff        <= '0;
         seq_ff       <= '0;
         time_ff      <= '0;
         prev_seq_ff  <= '0;
         prev_dc_ff   <= '0;
         seen_ff      <= 1'b0;
         fab_tot_ff   <= '0;
         net_tot_ff   <= '0;
         gt_ff        <= 1'b0;
         eq_ff        <= 1'b0;
         gap_ff       <= '0;
      end else begin
         if (csr_valid && csr_ready) begin
            chan_ff <= csr_data[0];
         end
         if (req_tvalid && req_tready) begin
            in_valid_ff <= 1'b1;
         end else if (proc) begin
            in_valid_ff <= 1'b0;
         end
         if (out_free) begin
            rsp_valid_ff <= emit;
         end
         pos_ff      <= pos_in;
         acc_ff      <= acc_in;
         dec_ff      <= dec_in;
         pw_ff       <= pw_in;
         seq_ff      <= seq_in;
         time_ff     <= time_in;
         prev_seq_ff <= prev_seq_in;
         prev_dc_ff  <= prev_dc_in;
         seen_ff     <= seen_in;
         fab_tot_ff  <= fab_tot_in;
         net_tot_ff  <= net_tot_in;
         gt_ff       <= gt_in;
         eq_ff       <= eq_in;
         gap_ff      <= gap_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_word_ff  <= req_tdata[63:0];
         in_bytes_ff <= req_tdata[78:64];
         in_last_ff  <= req_tlast;
      end
      if (emit) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_ff.kind;
   assign rsp_tlast  = rsp_ff.last_pair;
   assign rsp_tdata  = {4'd0,
                        rsp_ff.sample_second,
                        rsp_ff.sample_first,
                        rsp_ff.network_drop_total,
                        rsp_ff.fabric_drop_total,
                        rsp_ff.decimation_log,
                        rsp_ff.samples_per_channel,
                        rsp_ff.frame_time,
                        rsp_ff.frame_seq};

   assert property (@(posedge clock) disable iff (reset)
      emit && rsp_in.kind == KindHeader |=> seen_ff)
      else $error("header item left drop tracking unarmed");

   assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_word_ff) && $stable(pos_ff))
      else $error("stalled item lost or state advanced");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_ff.last_pair |-> rsp_ff.kind == KindPair)
      else $error("last pair flagged on a header item");

   assert property (@(posedge clock) disable iff (reset)
      emit && rsp_in.kind == KindPair |-> acc_ff && pos_ff >= PosPayload)
      else $error("sample pair outside an accepted payload");

endmodule
